FILE: rtl/dsaq_pkg.sv
package dsaq_pkg;

   localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;
   localparam logic [15:0] HOLD_OFF_RESET  = 16'd2000;
   localparam logic [11:0] EAR_THR_RESET   = 12'd184;
   localparam logic [11:0] MAR_THR_RESET   = 12'd614;
   localparam logic [10:0] SMOKE_A_RESET   = 11'd614;
   localparam logic [10:0] SMOKE_B_RESET   = 11'd973;
   localparam logic [10:0] CALL_THR_RESET  = 11'd614;

   localparam logic [2:0] CSR_TIMEOUT  = 3'd0;
   localparam logic [2:0] CSR_HOLD_OFF = 3'd1;
   localparam logic [2:0] CSR_EAR_THR  = 3'd2;
   localparam logic [2:0] CSR_MAR_THR  = 3'd3;
   localparam logic [2:0] CSR_SMOKE_A  = 3'd4;
   localparam logic [2:0] CSR_SMOKE_B  = 3'd5;
   localparam logic [2:0] CSR_CALL_THR = 3'd6;

   localparam logic [3:0] RUN_MAX         = 4'd15;
   localparam logic [3:0] SMOKE_FRAMES    = 4'd4;
   localparam logic [3:0] CALL_FRAMES     = 4'd4;
   localparam logic [3:0] DISTRACT_FRAMES = 4'd7;
   localparam logic [3:0] EYE_FRAMES      = 4'd9;
   localparam logic [3:0] YAWN_FRAMES     = 4'd11;

   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [15:0] hold_off_ms;
      logic [11:0] eye_closed_level;
      logic [11:0] mouth_open_level;
      logic [10:0] smoke_threshold_a;
      logic [10:0] smoke_threshold_b;
      logic [10:0] call_threshold;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic drop_full;
      logic read_oldest;
      logic drop_old;
      logic insert;
      logic div_start;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic expired;
      logic div_done;
   } sts_type;

endpackage

FILE: rtl/driver_state_alert_qualifier_unit.sv
// Driver state alert qualifier.
// Input channel req_*: one item per video frame with its timestamp and
// classifier features; timestamps should not decrease.
// Result channel rsp_*: one item per input item carrying five alert flags.
// Configuration port csr_*: write enable, register index, 16-bit data;
// write only while no item is in flight.
// Per item: the oldest entry of a full history is dropped, then history
// entries are read and compared in turn, each expired entry dropped, until
// one has not expired or the history is empty; the item is then inserted,
// the rounding divide of the eye-ratio mean runs (one quotient bit per
// cycle) and the run counts are updated. The expiry walk sets the worst
// case, when a full history expires at once.
// One item is in flight at a time; the next item is taken the cycle after
// the result is taken. A stalled receiver holds the result and blocks input.
// Reset empties the history, clears all run counts and hold-off state, and
// restores the register defaults; no clearing pass is needed.
module driver_state_alert_qualifier_unit #(
   parameter int HISTORY_DEPTH = 128,
   parameter int SMOOTH_LEN    = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_timestamp_ms,
   input  logic [11:0] req_ear_ratio,
   input  logic [11:0] req_mouth_ratio,
   input  logic [10:0] req_smoke_score_a,
   input  logic [10:0] req_smoke_score_b,
   input  logic [10:0] req_call_left_score,
   input  logic [10:0] req_call_right_score,
   input  logic [3:0]  req_detector_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_smoking_flag,
   output logic        rsp_calling_flag,
   output logic        rsp_distracted_flag,
   output logic        rsp_yawning_flag,
   output logic        rsp_eyes_closed_flag,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   dsaq_pkg::cfg_type cfg_ff;
   dsaq_pkg::cmd_type cmd;
   dsaq_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms        <= dsaq_pkg::TIMEOUT_RESET;
         cfg_ff.hold_off_ms       <= dsaq_pkg::HOLD_OFF_RESET;
         cfg_ff.eye_closed_level  <= dsaq_pkg::EAR_THR_RESET;
         cfg_ff.mouth_open_level  <= dsaq_pkg::MAR_THR_RESET;
         cfg_ff.smoke_threshold_a <= dsaq_pkg::SMOKE_A_RESET;
         cfg_ff.smoke_threshold_b <= dsaq_pkg::SMOKE_B_RESET;
         cfg_ff.call_threshold    <= dsaq_pkg::CALL_THR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dsaq_pkg::CSR_TIMEOUT:  cfg_ff.timeout_ms        <= csr_data;
            dsaq_pkg::CSR_HOLD_OFF: cfg_ff.hold_off_ms       <= csr_data;
            dsaq_pkg::CSR_EAR_THR:  cfg_ff.eye_closed_level  <= csr_data[11:0];
            dsaq_pkg::CSR_MAR_THR:  cfg_ff.mouth_open_level  <= csr_data[11:0];
            dsaq_pkg::CSR_SMOKE_A:  cfg_ff.smoke_threshold_a <= csr_data[10:0];
            dsaq_pkg::CSR_SMOKE_B:  cfg_ff.smoke_threshold_b <= csr_data[10:0];
            dsaq_pkg::CSR_CALL_THR: cfg_ff.call_threshold    <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   dsaq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dsaq_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SMOOTH_LEN    (SMOOTH_LEN)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .cfg                  (cfg_ff),
      .req_timestamp_ms     (req_timestamp_ms),
      .req_ear_ratio        (req_ear_ratio),
      .req_mouth_ratio      (req_mouth_ratio),
      .req_smoke_score_a    (req_smoke_score_a),
      .req_smoke_score_b    (req_smoke_score_b),
      .req_call_left_score  (req_call_left_score),
      .req_call_right_score (req_call_right_score),
      .req_detector_id      (req_detector_id),
      .rsp_smoking_flag     (rsp_smoking_flag),
      .rsp_calling_flag     (rsp_calling_flag),
      .rsp_distracted_flag  (rsp_distracted_flag),
      .rsp_yawning_flag     (rsp_yawning_flag),
      .rsp_eyes_closed_flag (rsp_eyes_closed_flag)
   );

endmodule

FILE: rtl/dsaq_ctrl.sv
module dsaq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dsaq_pkg::sts_type sts,
   output dsaq_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_FULL, S_READ, S_CHECK, S_INSERT, S_DIV, S_DONE, S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_FULL;
            end
         end
         S_FULL: begin
            if (sts.full) cmd.drop_full = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            if (sts.empty) begin
               state_in = S_INSERT;
            end else begin
               cmd.read_oldest = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.expired) begin
               cmd.drop_old = 1'b1;
               state_in = S_READ;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            cmd.insert    = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_load_then_full: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_FULL) else $error("load did not advance");
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish without result");
`endif

endmodule

FILE: rtl/dsaq_datapath.sv
module dsaq_datapath #(
   parameter int HISTORY_DEPTH = 128,
   parameter int SMOOTH_LEN    = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  dsaq_pkg::cmd_type cmd,
   output dsaq_pkg::sts_type sts,
   input  dsaq_pkg::cfg_type cfg,
   input  logic [31:0]       req_timestamp_ms,
   input  logic [11:0]       req_ear_ratio,
   input  logic [11:0]       req_mouth_ratio,
   input  logic [10:0]       req_smoke_score_a,
   input  logic [10:0]       req_smoke_score_b,
   input  logic [10:0]       req_call_left_score,
   input  logic [10:0]       req_call_right_score,
   input  logic [3:0]        req_detector_id,
   output logic              rsp_smoking_flag,
   output logic              rsp_calling_flag,
   output logic              rsp_distracted_flag,
   output logic              rsp_yawning_flag,
   output logic              rsp_eyes_closed_flag
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int NW = $clog2(SMOOTH_LEN + 1);
   localparam int SW = 12 + NW + 1;
   localparam logic [3:0] RUN_MAX_C = dsaq_pkg::RUN_MAX;

   logic [31:0] mem [HISTORY_DEPTH];
   logic [31:0] rd_ff;

   logic [31:0] ts_ff;
   logic [11:0] ear_ff, mar_ff;
   logic [10:0] sa_ff, sb_ff, cl_ff, cr_ff;
   logic [3:0]  det_ff;

   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;
   logic [11:0]   smooth_ff;
   logic [3:0]    run_sa_ff, run_sb_ff, run_cl_ff, run_cr_ff, run_eye_ff, run_yawn_ff;
   logic [3:0]    run_det_ff, prev_det_ff;
   logic [31:0]   last_alert_ff;
   logic          alert_seen_ff;
   logic [4:0]    flags_ff;

   logic [AW-1:0] oldest_inc, wr_pos;
   logic [AW:0]   pos_sum;

   assign oldest_inc = (oldest_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
   assign pos_sum = {1'b0, oldest_ff} + (AW+1)'(count_ff);
   assign wr_pos = (pos_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                   AW'(pos_sum - (AW+1)'(HISTORY_DEPTH)) : pos_sum[AW-1:0];

   assign sts.full    = (count_ff == CW'(HISTORY_DEPTH));
   assign sts.empty   = (count_ff == '0);
   assign sts.expired = ({1'b0, rd_ff} + 33'(cfg.timeout_ms)) < {1'b0, ts_ff};

   always_ff @(posedge clock) begin
      if (cmd.insert) mem[wr_pos] <= ts_ff;
      if (cmd.read_oldest) rd_ff <= mem[oldest_ff];
      if (cmd.load) begin
         ts_ff  <= req_timestamp_ms;
         ear_ff <= req_ear_ratio;
         mar_ff <= req_mouth_ratio;
         sa_ff  <= req_smoke_score_a;
         sb_ff  <= req_smoke_score_b;
         cl_ff  <= req_call_left_score;
         cr_ff  <= req_call_right_score;
         det_ff <= req_detector_id;
      end
   end

   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      if (cmd.drop_full || cmd.drop_old) begin
         oldest_in = oldest_inc;
         count_in  = count_ff - 1'b1;
      end
      if (cmd.insert) count_in = count_ff + 1'b1;
   end

   // smoothing: restoring divide, one quotient bit a cycle
   logic [NW-1:0] num_ff;
   logic [SW-1:0] rem_ff, dvd_ff;
   logic [11:0]   quo_ff;
   logic [4:0]    div_cnt_ff;
   logic          div_busy_ff;
   logic [CW-1:0] cnt_new;
   logic [NW-1:0] num_c;
   logic [11:0]   prev_c;
   logic [SW-1:0] dvd_c, rem_sh;

   assign cnt_new = count_ff + 1'b1;
   assign num_c   = (cnt_new < CW'(SMOOTH_LEN)) ? NW'(cnt_new) : NW'(SMOOTH_LEN);
   assign prev_c  = (cnt_new == CW'(1)) ? ear_ff : smooth_ff;
   assign dvd_c   = SW'(ear_ff) + SW'(prev_c) * SW'(num_c - 1'b1) + SW'(num_c >> 1);
   assign rem_sh  = {rem_ff[SW-2:0], dvd_ff[SW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= 5'(SW - 1);
         num_ff      <= num_c;
         dvd_ff      <= dvd_c;
         rem_ff      <= '0;
         quo_ff      <= '0;
      end else if (div_busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         if (rem_sh >= SW'(num_ff)) begin
            rem_ff <= rem_sh - SW'(num_ff);
            quo_ff <= {quo_ff[10:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[10:0], 1'b0};
         end
         if (div_cnt_ff == '0) div_busy_ff <= 1'b0;
         else div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   assign sts.div_done = div_busy_ff && (div_cnt_ff == '0);

   function automatic logic [3:0] next_run(input logic [3:0] run, input logic hit,
                                           input logic [CW-1:0] cnt);
      logic [CW:0] r;
      begin
         r = (CW+1)'(run) + 1'b1;
         if (r > (CW+1)'(cnt)) r = (CW+1)'(cnt);
         if (r > (CW+1)'(dsaq_pkg::RUN_MAX)) r = (CW+1)'(dsaq_pkg::RUN_MAX);
         next_run = hit ? r[3:0] : 4'd0;
      end
   endfunction

   logic [3:0] n_sa, n_sb, n_cl, n_cr, n_eye, n_yawn, n_det;
   logic       smk, cal, dis, yaw, eyes, any, held, det_ok;
   logic [31:0] last_c;

   always_comb begin
      n_sa   = next_run(run_sa_ff, sa_ff >= cfg.smoke_threshold_a, count_ff);
      n_sb   = next_run(run_sb_ff, sb_ff >= cfg.smoke_threshold_b, count_ff);
      n_cl   = next_run(run_cl_ff, cl_ff >= cfg.call_threshold, count_ff);
      n_cr   = next_run(run_cr_ff, cr_ff >= cfg.call_threshold, count_ff);
      n_yawn = next_run(run_yawn_ff, mar_ff >= cfg.mouth_open_level, count_ff);
      n_eye  = next_run(run_eye_ff, smooth_ff <= cfg.eye_closed_level, count_ff);
      n_det  = next_run(run_det_ff, det_ff == prev_det_ff, count_ff);
      if (n_det == 4'd0) n_det = 4'd1;
      smk    = (n_sa >= dsaq_pkg::SMOKE_FRAMES) || (n_sb >= dsaq_pkg::SMOKE_FRAMES);
      cal    = (n_cl >= dsaq_pkg::CALL_FRAMES) != (n_cr >= dsaq_pkg::CALL_FRAMES);
      det_ok = (det_ff != 4'd0) && (det_ff != 4'd3) && (det_ff != 4'd4);
      dis    = det_ok && (n_det >= dsaq_pkg::DISTRACT_FRAMES);
      yaw    = n_yawn >= dsaq_pkg::YAWN_FRAMES;
      any    = smk || cal || dis || yaw;
      last_c = any ? ts_ff : last_alert_ff;
      held   = (any || alert_seen_ff) && ((ts_ff - last_c) < 32'(cfg.hold_off_ms));
      eyes   = !held && (n_eye >= dsaq_pkg::EYE_FRAMES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff     <= '0;
         count_ff      <= '0;
         smooth_ff     <= '0;
         run_sa_ff     <= '0;
         run_sb_ff     <= '0;
         run_cl_ff     <= '0;
         run_cr_ff     <= '0;
         run_eye_ff    <= '0;
         run_yawn_ff   <= '0;
         run_det_ff    <= '0;
         prev_det_ff   <= '0;
         last_alert_ff <= '0;
         alert_seen_ff <= 1'b0;
         flags_ff      <= '0;
      end else begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         if (sts.div_done) smooth_ff <= {quo_ff[10:0], rem_sh >= SW'(num_ff)};
         if (cmd.finish) begin
            run_sa_ff     <= n_sa;
            run_sb_ff     <= n_sb;
            run_cl_ff     <= n_cl;
            run_cr_ff     <= n_cr;
            run_eye_ff    <= n_eye;
            run_yawn_ff   <= n_yawn;
            run_det_ff    <= n_det;
            prev_det_ff   <= det_ff;
            last_alert_ff <= last_c;
            alert_seen_ff <= alert_seen_ff || any;
            flags_ff      <= {eyes, yaw, dis, cal, smk};
         end
      end
   end

   assign rsp_smoking_flag     = flags_ff[0];
   assign rsp_calling_flag     = flags_ff[1];
   assign rsp_distracted_flag  = flags_ff[2];
   assign rsp_yawning_flag     = flags_ff[3];
   assign rsp_eyes_closed_flag = flags_ff[4];

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HISTORY_DEPTH)) else $error("history overflow");
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !sts.full) else $error("insert into full history");
   a_runs_clamped: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> run_sa_ff <= RUN_MAX_C && run_eye_ff <= RUN_MAX_C)
      else $error("run count exceeds limit");
`endif

endmodule

FILE: bench/dsaq_checker.sv
`timescale 1ns / 100ps

module dsaq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_timestamp_ms,
   input  logic [11:0] req_ear_ratio,
   input  logic [11:0] req_mouth_ratio,
   input  logic [10:0] req_smoke_score_a,
   input  logic [10:0] req_smoke_score_b,
   input  logic [10:0] req_call_left_score,
   input  logic [10:0] req_call_right_score,
   input  logic [3:0]  req_detector_id,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_smoking_flag,
   input  logic        rsp_calling_flag,
   input  logic        rsp_distracted_flag,
   input  logic        rsp_yawning_flag,
   input  logic        rsp_eyes_closed_flag,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          error_count,
   output int          pending_flags
);

   localparam int DEPTH = 128;
   localparam int SMOOTH = 5;

   dsaq_pkg::cfg_type cfg;
   logic [31:0] stamps [DEPTH];
   int          head;
   int          fill;
   logic [11:0] ear_mean;
   int          run_sa, run_sb, run_cl, run_cr, run_eye, run_yawn, run_det;
   logic [3:0]  last_det;
   logic [31:0] alert_stamp;
   logic        alert_armed;
   logic [4:0]  flags_due [$];
   int          checked;

   function automatic int bump(int run, bit hit);
      int r;
      if (!hit) return 0;
      r = run + 1;
      if (r > fill) r = fill;
      if (r > dsaq_pkg::RUN_MAX) r = dsaq_pkg::RUN_MAX;
      return r;
   endfunction

   task automatic qualify_frame(output logic [4:0] flags);
      int num;
      int prev;
      int pos;
      bit smoking, calling, distracted, yawning, held, valid_det;
      if (fill >= DEPTH) begin
         head = (head + 1) % DEPTH;
         fill--;
      end
      while (fill > 0 && ({1'b0, stamps[head]} + {17'd0, cfg.timeout_ms})
             < {1'b0, req_timestamp_ms}) begin
         head = (head + 1) % DEPTH;
         fill--;
      end
      pos = (head + fill) % DEPTH;
      stamps[pos] = req_timestamp_ms;
      fill++;
      num = fill < SMOOTH ? fill : SMOOTH;
      prev = (fill == 1) ? req_ear_ratio : ear_mean;
      ear_mean = 12'((req_ear_ratio + prev * (num - 1) + num / 2) / num);
      run_sa = bump(run_sa, req_smoke_score_a >= cfg.smoke_threshold_a);
      run_sb = bump(run_sb, req_smoke_score_b >= cfg.smoke_threshold_b);
      run_cl = bump(run_cl, req_call_left_score >= cfg.call_threshold);
      run_cr = bump(run_cr, req_call_right_score >= cfg.call_threshold);
      run_yawn = bump(run_yawn, req_mouth_ratio >= cfg.mouth_open_level);
      run_eye = bump(run_eye, ear_mean <= cfg.eye_closed_level);
      run_det = bump(run_det, req_detector_id == last_det);
      if (run_det == 0) run_det = 1;
      last_det = req_detector_id;
      smoking = run_sa >= dsaq_pkg::SMOKE_FRAMES || run_sb >= dsaq_pkg::SMOKE_FRAMES;
      calling = (run_cl >= dsaq_pkg::CALL_FRAMES) != (run_cr >= dsaq_pkg::CALL_FRAMES);
      valid_det = req_detector_id != 0 && req_detector_id != 3 && req_detector_id != 4;
      distracted = valid_det && run_det >= dsaq_pkg::DISTRACT_FRAMES;
      yawning = run_yawn >= dsaq_pkg::YAWN_FRAMES;
      if (smoking || calling || distracted || yawning) begin
         alert_stamp = req_timestamp_ms;
         alert_armed = 1'b1;
      end
      held = alert_armed && (32'(req_timestamp_ms - alert_stamp) < {16'd0, cfg.hold_off_ms});
      flags = {smoking, calling, distracted, yawning,
               !held && run_eye >= dsaq_pkg::EYE_FRAMES};
   endtask

   always @(posedge clock) begin
      logic [4:0] want;
      logic [4:0] got;
      if (reset) begin
         cfg <= '{dsaq_pkg::TIMEOUT_RESET, dsaq_pkg::HOLD_OFF_RESET,
                  dsaq_pkg::EAR_THR_RESET, dsaq_pkg::MAR_THR_RESET,
                  dsaq_pkg::SMOKE_A_RESET, dsaq_pkg::SMOKE_B_RESET,
                  dsaq_pkg::CALL_THR_RESET};
         head = 0;
         fill = 0;
         ear_mean = '0;
         run_sa = 0; run_sb = 0; run_cl = 0; run_cr = 0;
         run_eye = 0; run_yawn = 0; run_det = 0;
         last_det = '0;
         alert_stamp = '0;
         alert_armed = 1'b0;
         flags_due.delete();
         error_count <= 0;
         pending_flags <= 0;
         checked = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               dsaq_pkg::CSR_TIMEOUT:  cfg.timeout_ms <= csr_data;
               dsaq_pkg::CSR_HOLD_OFF: cfg.hold_off_ms <= csr_data;
               dsaq_pkg::CSR_EAR_THR:  cfg.eye_closed_level <= csr_data[11:0];
               dsaq_pkg::CSR_MAR_THR:  cfg.mouth_open_level <= csr_data[11:0];
               dsaq_pkg::CSR_SMOKE_A:  cfg.smoke_threshold_a <= csr_data[10:0];
               dsaq_pkg::CSR_SMOKE_B:  cfg.smoke_threshold_b <= csr_data[10:0];
               dsaq_pkg::CSR_CALL_THR: cfg.call_threshold <= csr_data[10:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_smoking_flag, rsp_calling_flag, rsp_distracted_flag,
                   rsp_yawning_flag, rsp_eyes_closed_flag};
            checked++;
            if (flags_due.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected item %0d: flags %b", checked, got);
               error_count <= error_count + 1;
            end else begin
               want = flags_due.pop_front();
               if (want !== got) begin
                  if (error_count < 10)
                     $display("item %0d: smoke/call/distr/yawn/eyes expected %b got %b",
                              checked, want, got);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            qualify_frame(want);
            flags_due = {flags_due, want};
         end
         pending_flags <= flags_due.size();
      end
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int LIMIT = 3000000;
   localparam int PHASE_ITEMS = 106;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_timestamp_ms;
   logic [11:0] req_ear_ratio;
   logic [11:0] req_mouth_ratio;
   logic [10:0] req_smoke_score_a;
   logic [10:0] req_smoke_score_b;
   logic [10:0] req_call_left_score;
   logic [10:0] req_call_right_score;
   logic [3:0]  req_detector_id;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_smoking_flag;
   logic        rsp_calling_flag;
   logic        rsp_distracted_flag;
   logic        rsp_yawning_flag;
   logic        rsp_eyes_closed_flag;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   int          error_count;
   int          pending_flags;

   int          idle_pct;
   int          stall_pct;
   int          frames_sent;
   logic [31:0] now_ms;
   dsaq_pkg::cfg_type thr;
   logic [6:0]  trend;
   int          trend_left;

   driver_state_alert_qualifier_unit dut (.*);
   dsaq_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d frames sent", LIMIT, frames_sent);
      $display("RESULT: ERROR");
      $finish;
   end

   always @(negedge clock)
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);

   task automatic send_frame(input logic [31:0] ts, input logic [11:0] ear,
                             input logic [11:0] mar, input logic [10:0] sa,
                             input logic [10:0] sb, input logic [10:0] cl,
                             input logic [10:0] cr, input logic [3:0] det);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_timestamp_ms = ts;
      req_ear_ratio = ear;
      req_mouth_ratio = mar;
      req_smoke_score_a = sa;
      req_smoke_score_b = sb;
      req_call_left_score = cl;
      req_call_right_score = cr;
      req_detector_id = det;
      do @(posedge clock); while (!req_ready);
      frames_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = val;
      case (idx)
         dsaq_pkg::CSR_TIMEOUT:  thr.timeout_ms = val;
         dsaq_pkg::CSR_HOLD_OFF: thr.hold_off_ms = val;
         dsaq_pkg::CSR_EAR_THR:  thr.eye_closed_level = val[11:0];
         dsaq_pkg::CSR_MAR_THR:  thr.mouth_open_level = val[11:0];
         dsaq_pkg::CSR_SMOKE_A:  thr.smoke_threshold_a = val[10:0];
         dsaq_pkg::CSR_SMOKE_B:  thr.smoke_threshold_b = val[10:0];
         dsaq_pkg::CSR_CALL_THR: thr.call_threshold = val[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic drain;
      while (pending_flags != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [10:0] score(input bit hit, input logic [10:0] t);
      if (hit) return (t > 1024) ? 11'd1024 : 11'($urandom_range(1024, t));
      return (t == 0) ? 11'd0 : 11'($urandom_range(t - 1, 0));
   endfunction

   function automatic logic [11:0] ratio_at_least(input bit hit, input logic [11:0] t);
      if (hit) return 12'($urandom_range(4095, t));
      return (t == 0) ? 12'd0 : 12'($urandom_range(t - 1, 0));
   endfunction

   task automatic random_frame;
      logic [3:0]  det;
      logic [6:0]  h;
      logic [11:0] ear;
      int          pick;
      if (trend_left == 0) begin
         trend = 7'($urandom);
         trend_left = $urandom_range(25, 1);
      end
      trend_left--;
      pick = $urandom_range(99);
      if (pick < 80) now_ms += $urandom_range(60);
      else if (pick < 95) now_ms += $urandom_range(2 * thr.timeout_ms + 2);
      else if (pick < 98) now_ms -= $urandom_range(3000);
      else now_ms = $urandom;
      if ($urandom_range(99) < 10) begin
         send_frame(now_ms, 12'($urandom), 12'($urandom), 11'($urandom_range(1024)),
                    11'($urandom_range(1024)), 11'($urandom_range(1024)),
                    11'($urandom_range(1024)), 4'($urandom));
      end else begin
         h = trend;
         for (int i = 0; i < 7; i++)
            if ($urandom_range(99) < 8) h[i] = ~h[i];
         det = h[6] ? req_detector_id : 4'($urandom);
         ear = h[5] ? 12'($urandom_range(thr.eye_closed_level))
                    : 12'($urandom_range(4095, thr.eye_closed_level));
         send_frame(now_ms, ear, ratio_at_least(h[4], thr.mouth_open_level),
                    score(h[0], thr.smoke_threshold_a), score(h[1], thr.smoke_threshold_b),
                    score(h[2], thr.call_threshold), score(h[3], thr.call_threshold), det);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_timestamp_ms = '0;
      req_ear_ratio = '0;
      req_mouth_ratio = '0;
      req_smoke_score_a = '0;
      req_smoke_score_b = '0;
      req_call_left_score = '0;
      req_call_right_score = '0;
      req_detector_id = '0;
      csr_write = 1'b0;
      csr_index = dsaq_pkg::CSR_TIMEOUT;
      csr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      frames_sent = 0;
      trend_left = 0;
      now_ms = '0;
      thr = '{dsaq_pkg::TIMEOUT_RESET, dsaq_pkg::HOLD_OFF_RESET,
              dsaq_pkg::EAR_THR_RESET, dsaq_pkg::MAR_THR_RESET,
              dsaq_pkg::SMOKE_A_RESET, dsaq_pkg::SMOKE_B_RESET,
              dsaq_pkg::CALL_THR_RESET};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, invalid detectors, equal and backward time
      send_frame(32'd0, 12'd0, 12'd0, 11'd0, 11'd0, 11'd0, 11'd0, 4'd0);
      send_frame(32'd0, 12'd4095, 12'd4095, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 4'd15);
      for (int i = 0; i < 12; i++)
         send_frame(32'd10 * i, 12'd50, 12'd4095, 11'd1024, 11'd0, 11'd1024, 11'd0,
                    (i < 6) ? 4'd3 : 4'd9);
      send_frame(32'd20, 12'd0, 12'd0, 11'd0, 11'd1024, 11'd0, 11'd1024, 4'd4);
      send_frame(32'd100000, 12'd0, 12'd0, 11'd0, 11'd0, 11'd0, 11'd0, 4'd0);
      send_frame(32'hFFFF_FFFF, 12'd4095, 12'd0, 11'd1024, 11'd1024, 11'd0, 11'd0, 4'd5);
      send_frame(32'hFFFF_FFFF, 12'd0, 12'd0, 11'd0, 11'd0, 11'd0, 11'd0, 4'd5);
      send_frame(32'h0000_0005, 12'd0, 12'd0, 11'd0, 11'd0, 11'd0, 11'd0, 4'd5);
      now_ms = 32'd5;

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         case (phase)
            0: ;
            1: begin
               write_reg(dsaq_pkg::CSR_TIMEOUT, 16'd1);
               write_reg(dsaq_pkg::CSR_HOLD_OFF, 16'd0);
               write_reg(dsaq_pkg::CSR_EAR_THR, 16'd0);
               write_reg(dsaq_pkg::CSR_MAR_THR, 16'd0);
               write_reg(dsaq_pkg::CSR_SMOKE_A, 16'd0);
               write_reg(dsaq_pkg::CSR_SMOKE_B, 16'd0);
               write_reg(dsaq_pkg::CSR_CALL_THR, 16'd0);
            end
            2: begin
               write_reg(dsaq_pkg::CSR_TIMEOUT, 16'd65535);
               write_reg(dsaq_pkg::CSR_HOLD_OFF, 16'd65535);
               write_reg(dsaq_pkg::CSR_EAR_THR, 16'd4095);
               write_reg(dsaq_pkg::CSR_MAR_THR, 16'd4095);
               write_reg(dsaq_pkg::CSR_SMOKE_A, 16'd1024);
               write_reg(dsaq_pkg::CSR_SMOKE_B, 16'd1024);
               write_reg(dsaq_pkg::CSR_CALL_THR, 16'd1024);
            end
            default: begin
               write_reg(dsaq_pkg::CSR_TIMEOUT, 16'($urandom_range(8000, 1)));
               write_reg(dsaq_pkg::CSR_HOLD_OFF, 16'($urandom_range(65535)));
               write_reg(dsaq_pkg::CSR_EAR_THR, 16'($urandom_range(4095)));
               write_reg(dsaq_pkg::CSR_MAR_THR, 16'($urandom_range(4095)));
               write_reg(dsaq_pkg::CSR_SMOKE_A, 16'($urandom_range(1024)));
               write_reg(dsaq_pkg::CSR_SMOKE_B, 16'($urandom_range(1024)));
               write_reg(dsaq_pkg::CSR_CALL_THR, 16'($urandom_range(1024)));
            end
         endcase
         repeat (PHASE_ITEMS) random_frame();
      end

      while (pending_flags != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      $display("sent %0d frames over 8 register settings, including extremes", frames_sent);
      $display("idle and stall mixes on both channels, expiry and hold-off exercised");
      if (error_count == 0 && pending_flags == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/dsaq_pkg.sv
rtl/dsaq_ctrl.sv
rtl/dsaq_datapath.sv
rtl/driver_state_alert_qualifier_unit.sv
bench/dsaq_checker.sv
bench/tb_top.sv
